[rtl/core/bmtb_pkg.sv]
`timescale 1ns / 1ps

package bmtb_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int ALPHABET    = 256;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int SGN_W       = CNT_W + 2;
    localparam int BYTE_W      = 8;
    localparam int SYM_W       = $clog2(ALPHABET);

    typedef enum logic [1:0] {
        OP_LOAD       = 2'd0,
        OP_QUERY_SKIP = 2'd1,
        OP_QUERY_GS   = 2'd2,
        OP_UNUSED     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_NOT_BUILT = 2'd2,
        ST_BAD_POS   = 2'd3
    } status_t;

    // Requests from the command front end to the table engine.
    typedef struct packed {
        logic              pat_we;
        logic [IDX_W-1:0]  pat_addr;
        logic [BYTE_W-1:0] pat_data;
        logic              build;
        logic [CNT_W-1:0]  build_len;
        logic [CNT_W-1:0]  fill_val;
        logic              build_gs;
        logic              rd_skip;
        logic              rd_shift;
        logic [SYM_W-1:0]  rd_addr;
    } bmtb_req_t;

    typedef struct packed {
        logic             done;
        logic             rd_valid;
        logic [CNT_W-1:0] rd_data;
    } bmtb_rsp_t;

endpackage

[rtl/core/bmtb_engine.sv]
`timescale 1ns / 1ps

module bmtb_engine
    import bmtb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bmtb_req_t req,
    output bmtb_rsp_t rsp
);

    typedef enum logic [16:0] {
        C_IDLE     = 17'h00001,
        C_FILL     = 17'h00002,
        C_SCAN_RD  = 17'h00004,
        C_SCAN_WR  = 17'h00008,
        C_GS_START = 17'h00010,
        C_GS_I     = 17'h00020,
        C_GS_M     = 17'h00040,
        C_GS_E     = 17'h00080,
        C_GS_R     = 17'h00100,
        C_SH_INIT  = 17'h00200,
        C_SH_K     = 17'h00400,
        C_SH_KC    = 17'h00800,
        C_SH_J     = 17'h01000,
        C_P3_RD    = 17'h02000,
        C_P3_S     = 17'h04000,
        C_P3_C     = 17'h08000,
        C_DONE     = 17'h10000
    } cstate_t;

    cstate_t state_reg, state_next;

    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             gs_reg, gs_next;
    logic [SYM_W-1:0] b_reg, b_next;
    logic signed [SGN_W-1:0] i_reg, i_next, f_reg, f_next, g_reg, g_next;
    logic [CNT_W-1:0] j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             rd_sel_reg, rd_sel_next;

    // Memories.
    logic [BYTE_W-1:0] pat_mem [MAX_PATTERN];
    logic [CNT_W-1:0]  skip_mem [ALPHABET];
    logic [CNT_W-1:0]  suff_mem [MAX_PATTERN];
    logic [CNT_W-1:0]  shift_mem [MAX_PATTERN];

    logic [BYTE_W-1:0] pat_a_q, pat_b_q;
    logic [CNT_W-1:0]  skip_q, suff_q, shift_q;
    logic [IDX_W-1:0]  pat_a_ra, pat_b_ra, suff_ra, suff_wa, shift_ra, shift_wa;
    logic [SYM_W-1:0]  skip_ra, skip_wa;
    logic              skip_we, suff_we, shift_we;
    logic [CNT_W-1:0]  skip_wd, suff_wd, shift_wd;

    logic signed [SGN_W-1:0] n_s, mirror, g_new, g_dec, suff_s;
    logic [CNT_W-1:0]        cap_scan, n_m1, n_mk, cap3;

    always_ff @(posedge clk)
    begin
        if (req.pat_we)
        begin
            pat_mem[req.pat_addr] <= req.pat_data;
        end
        pat_a_q <= pat_mem[pat_a_ra];
        pat_b_q <= pat_mem[pat_b_ra];
    end

    always_ff @(posedge clk)
    begin
        if (skip_we)
        begin
            skip_mem[skip_wa] <= skip_wd;
        end
        skip_q <= skip_mem[skip_ra];
    end

    always_ff @(posedge clk)
    begin
        if (suff_we)
        begin
            suff_mem[suff_wa] <= suff_wd;
        end
        suff_q <= suff_mem[suff_ra];
    end

    always_ff @(posedge clk)
    begin
        if (shift_we)
        begin
            shift_mem[shift_wa] <= shift_wd;
        end
        shift_q <= shift_mem[shift_ra];
    end

    always_comb
    begin
        n_s      = $signed({2'b00, n_reg});
        mirror   = i_reg + n_s - SGN_W'(1) - f_reg;
        g_new    = (i_reg < g_reg) ? i_reg : g_reg;
        g_dec    = g_reg - SGN_W'(1);
        suff_s   = $signed({2'b00, suff_q});
        n_m1     = n_reg - CNT_W'(1);
        cap_scan = n_m1 - CNT_W'(i_reg);
        n_mk     = n_reg - k_reg;
        cap3     = n_m1 - k_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        fill_next     = fill_reg;
        gs_next       = gs_reg;
        b_next        = b_reg;
        i_next        = i_reg;
        f_next        = f_reg;
        g_next        = g_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        pos_next      = pos_reg;
        rd_valid_next = 1'b0;
        rd_sel_next   = rd_sel_reg;

        pat_a_ra = i_reg[IDX_W-1:0];
        pat_b_ra = i_reg[IDX_W-1:0];
        suff_ra  = k_reg[IDX_W-1:0];
        shift_ra = req.rd_addr[IDX_W-1:0];
        skip_ra  = req.rd_addr;
        skip_we  = 1'b0;
        skip_wa  = b_reg;
        skip_wd  = fill_reg;
        suff_we  = 1'b0;
        suff_wa  = i_reg[IDX_W-1:0];
        suff_wd  = CNT_W'(f_reg - g_reg);
        shift_we = 1'b0;
        shift_wa = j_reg[IDX_W-1:0];
        shift_wd = n_reg;

        case (state_reg)
            C_IDLE:
            begin
                if (req.build)
                begin
                    n_next     = req.build_len;
                    fill_next  = req.fill_val;
                    gs_next    = req.build_gs;
                    b_next     = '0;
                    state_next = C_FILL;
                end
                else if (req.rd_skip || req.rd_shift)
                begin
                    rd_valid_next = 1'b1;
                    rd_sel_next   = req.rd_shift;
                end
            end
            C_FILL:
            begin
                skip_we = 1'b1;
                b_next  = b_reg + SYM_W'(1);
                if (b_reg == SYM_W'(ALPHABET - 1))
                begin
                    i_next = '0;
                    if (n_reg >= CNT_W'(2))
                    begin
                        state_next = C_SCAN_RD;
                    end
                    else
                    begin
                        state_next = gs_reg ? C_GS_START : C_DONE;
                    end
                end
            end
            C_SCAN_RD:
            begin
                state_next = C_SCAN_WR;
            end
            C_SCAN_WR:
            begin
                // Caps shrink as the position advances, so a plain overwrite
                // leaves the smallest cap for each byte value.
                skip_we = 1'b1;
                skip_wa = pat_a_q;
                skip_wd = (cap_scan < fill_reg) ? cap_scan : fill_reg;
                i_next  = i_reg + SGN_W'(1);
                if (i_reg + SGN_W'(2) < n_s)
                begin
                    state_next = C_SCAN_RD;
                end
                else
                begin
                    state_next = gs_reg ? C_GS_START : C_DONE;
                end
            end
            C_GS_START:
            begin
                suff_we = 1'b1;
                suff_wa = n_m1[IDX_W-1:0];
                suff_wd = n_reg;
                f_next  = '0;
                g_next  = n_s - SGN_W'(1);
                i_next  = n_s - SGN_W'(2);
                j_next  = '0;
                state_next = (n_reg >= CNT_W'(2)) ? C_GS_I : C_SH_INIT;
            end
            C_GS_I:
            begin
                suff_ra = mirror[IDX_W-1:0];
                if (i_reg > g_reg && mirror < n_s)
                begin
                    state_next = C_GS_M;
                end
                else
                begin
                    state_next = C_GS_E;
                end
            end
            C_GS_M:
            begin
                if (suff_s < i_reg - g_reg)
                begin
                    suff_we = 1'b1;
                    suff_wd = suff_q;
                    if (i_reg == '0)
                    begin
                        state_next = C_SH_INIT;
                    end
                    else
                    begin
                        i_next     = i_reg - SGN_W'(1);
                        state_next = C_GS_I;
                    end
                end
                else
                begin
                    state_next = C_GS_E;
                end
            end
            C_GS_E:
            begin
                g_next     = g_new;
                f_next     = i_reg;
                pat_a_ra   = g_new[IDX_W-1:0];
                pat_b_ra   = IDX_W'(g_new + n_s - SGN_W'(1) - i_reg);
                state_next = C_GS_R;
            end
            C_GS_R:
            begin
                pat_a_ra = g_dec[IDX_W-1:0];
                pat_b_ra = IDX_W'(g_dec + n_s - SGN_W'(1) - f_reg);
                if (!g_reg[SGN_W-1] && pat_a_q == pat_b_q)
                begin
                    g_next = g_dec;
                end
                else
                begin
                    suff_we = 1'b1;
                    if (i_reg == '0)
                    begin
                        state_next = C_SH_INIT;
                    end
                    else
                    begin
                        i_next     = i_reg - SGN_W'(1);
                        state_next = C_GS_I;
                    end
                end
            end
            C_SH_INIT:
            begin
                shift_we = 1'b1;
                j_next   = j_reg + CNT_W'(1);
                if (j_reg == n_m1)
                begin
                    j_next     = '0;
                    k_next     = n_reg;
                    state_next = C_SH_K;
                end
            end
            C_SH_K:
            begin
                suff_ra    = IDX_W'(k_reg - CNT_W'(1));
                state_next = C_SH_KC;
            end
            C_SH_KC, C_SH_J:
            begin
                if (state_reg == C_SH_J && j_reg < n_mk)
                begin
                    shift_we = 1'b1;
                    shift_wd = n_mk;
                    j_next   = j_reg + CNT_W'(1);
                end
                else if (state_reg == C_SH_KC && suff_q == k_reg)
                begin
                    state_next = C_SH_J;
                end
                else if (k_reg == CNT_W'(1))
                begin
                    k_next     = '0;
                    state_next = (n_reg >= CNT_W'(2)) ? C_P3_RD : C_DONE;
                end
                else
                begin
                    k_next     = k_reg - CNT_W'(1);
                    state_next = C_SH_K;
                end
            end
            C_P3_RD:
            begin
                suff_ra    = k_reg[IDX_W-1:0];
                state_next = C_P3_S;
            end
            C_P3_S, C_P3_C:
            begin
                shift_ra = IDX_W'(n_m1 - suff_q);
                if (state_reg == C_P3_S && suff_q <= n_m1)
                begin
                    pos_next   = IDX_W'(n_m1 - suff_q);
                    state_next = C_P3_C;
                end
                else
                begin
                    if (state_reg == C_P3_C && shift_q > cap3)
                    begin
                        shift_we = 1'b1;
                        shift_wa = pos_reg;
                        shift_wd = cap3;
                    end
                    if (k_reg + CNT_W'(2) >= n_reg)
                    begin
                        state_next = C_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = C_P3_RD;
                    end
                end
            end
            C_DONE:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= C_IDLE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        fill_reg   <= fill_next;
        gs_reg     <= gs_next;
        b_reg      <= b_next;
        i_reg      <= i_next;
        f_reg      <= f_next;
        g_reg      <= g_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        rd_sel_reg <= rd_sel_next;
    end

    assign rsp.done     = (state_reg == C_DONE);
    assign rsp.rd_valid = rd_valid_reg;
    assign rsp.rd_data  = rd_sel_reg ? shift_q : skip_q;

endmodule

[rtl/core/boyer_moore_table_builder.sv]
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// command   start, busy             operation, byte_value, exact_byte, last_byte, position
// result    done (one-cycle strobe) shift_value, good_suffix_valid, pattern_length, status
// config    config_write            config_data (good-suffix minimum length)
//
// A transaction is taken when start is high and busy is low. Loads that do
// not end a pattern, error answers and the unused operation strobe done in
// the next cycle; a table query also passes the engine's rd_valid register.
// An error-free last byte, with busy high, fills the 256 skip entries, scans
// each byte before the last and runs the good-suffix passes when built.
// Reset clears the control state only, and the receiver cannot stall done.

module boyer_moore_table_builder
    import bmtb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        operation,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              exact_byte,
    input  logic              last_byte,
    input  logic [IDX_W-1:0]  position,
    output logic              done,
    output logic [CNT_W-1:0]  shift_value,
    output logic              good_suffix_valid,
    output logic [CNT_W-1:0]  pattern_length,
    output logic [1:0]        status,
    input  logic              config_write,
    input  logic [6:0]        config_data
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_BUILD = 3'b010,
        S_QUERY = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Pattern bookkeeping. The wildcard tracking replaces a scan of the
    // exact marks: only the last wildcard before the final byte matters,
    // because it caps every skip entry.
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             built_reg, built_next;
    logic             present_reg, present_next;
    logic             closed_reg, closed_next;
    logic             exact_only_reg, exact_only_next;
    logic             wild_seen_reg, wild_seen_next;
    logic [IDX_W-1:0] wild_idx_reg, wild_idx_next;
    logic [6:0]       minlen_reg;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] shift_reg, shift_next;
    status_t          status_reg, status_next;

    bmtb_req_t req;
    bmtb_rsp_t rsp;

    logic [CNT_W-1:0] cnt_eff;
    logic [6:0]       minlen_eff;
    op_t              op;

    assign op         = op_t'(operation);
    assign minlen_eff = (minlen_reg == 7'd0) ? 7'd1 : minlen_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        built_next      = built_reg;
        present_next    = present_reg;
        closed_next     = closed_reg;
        exact_only_next = exact_only_reg;
        wild_seen_next  = wild_seen_reg;
        wild_idx_next   = wild_idx_reg;
        done_next       = 1'b0;
        shift_next      = shift_reg;
        status_next     = status_reg;
        cnt_eff         = closed_reg ? '0 : cnt_reg;

        req           = '0;
        req.pat_addr  = cnt_eff[IDX_W-1:0];
        req.pat_data  = byte_value;
        req.rd_addr   = byte_value;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    shift_next  = '0;
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    case (op)
                        OP_LOAD:
                        begin
                            // A load after a closed pattern begins a new one.
                            if (closed_reg)
                            begin
                                ovf_next        = 1'b0;
                                built_next      = 1'b0;
                                present_next    = 1'b0;
                                closed_next     = 1'b0;
                                exact_only_next = 1'b1;
                                wild_seen_next  = 1'b0;
                            end
                            if (cnt_eff < CNT_W'(MAX_PATTERN))
                            begin
                                req.pat_we = 1'b1;
                                cnt_next   = cnt_eff + CNT_W'(1);
                                if (!exact_byte)
                                begin
                                    exact_only_next = 1'b0;
                                    if (!last_byte)
                                    begin
                                        wild_seen_next = 1'b1;
                                        wild_idx_next  = cnt_eff[IDX_W-1:0];
                                    end
                                end
                            end
                            else
                            begin
                                cnt_next = cnt_eff;
                                ovf_next = 1'b1;
                            end
                            if (ovf_next)
                            begin
                                status_next = ST_TOO_LONG;
                            end
                            if (last_byte)
                            begin
                                closed_next = 1'b1;
                                if (!ovf_next)
                                begin
                                    built_next    = 1'b1;
                                    present_next  = exact_only_next &&
                                                    (cnt_next >= minlen_eff);
                                    req.build     = 1'b1;
                                    req.build_len = cnt_next;
                                    req.build_gs  = present_next;
                                    req.fill_val  = wild_seen_next ?
                                        (cnt_next - CNT_W'(1) - CNT_W'(wild_idx_next)) :
                                        cnt_next;
                                    done_next     = 1'b0;
                                    state_next    = S_BUILD;
                                end
                            end
                        end
                        OP_QUERY_SKIP:
                        begin
                            if (!built_reg)
                            begin
                                status_next = ST_NOT_BUILT;
                            end
                            else
                            begin
                                req.rd_skip = 1'b1;
                                done_next   = 1'b0;
                                state_next  = S_QUERY;
                            end
                        end
                        OP_QUERY_GS:
                        begin
                            if (!built_reg || !present_reg)
                            begin
                                status_next = ST_NOT_BUILT;
                            end
                            else if (CNT_W'(position) >= cnt_reg)
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                req.rd_shift = 1'b1;
                                req.rd_addr  = SYM_W'(position);
                                done_next    = 1'b0;
                                state_next   = S_QUERY;
                            end
                        end
                        default:
                        begin
                            // The unused code answers with zeros and changes nothing.
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_BUILD:
            begin
                if (rsp.done)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_QUERY:
            begin
                if (rsp.rd_valid)
                begin
                    shift_next = rsp.rd_data;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            built_reg      <= 1'b0;
            present_reg    <= 1'b0;
            closed_reg     <= 1'b0;
            exact_only_reg <= 1'b1;
            wild_seen_reg  <= 1'b0;
            minlen_reg     <= 7'd4;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            built_reg      <= built_next;
            present_reg    <= present_next;
            closed_reg     <= closed_next;
            exact_only_reg <= exact_only_next;
            wild_seen_reg  <= wild_seen_next;
            done_reg       <= done_next;
            if (config_write)
            begin
                minlen_reg <= config_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wild_idx_reg <= wild_idx_next;
        shift_reg    <= shift_next;
        status_reg   <= status_next;
    end

    bmtb_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign shift_value       = shift_reg;
    assign status            = status_reg;
    assign good_suffix_valid = present_reg;
    assign pattern_length    = cnt_reg;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for boyer_moore_table_builder.
//
// Patterns are loaded byte by byte, then skip and good-suffix entries are read
// back with queries. A predictor in this file keeps its own copy of the pattern,
// the skip table, the suffix lengths and the shift table. It works out the
// expected result of every accepted transaction. A monitor compares each
// result strobe with the oldest expected result.

module tb_top;
    import bmtb_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;

    typedef struct packed {
        logic [6:0] shift;
        logic       gs_valid;
        logic [6:0] length;
        status_t    stat;
    } answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        operation = OP_LOAD;
    logic [BYTE_W-1:0] byte_value = '0;
    logic              exact_byte = 1'b0;
    logic              last_byte = 1'b0;
    logic [IDX_W-1:0]  position = '0;
    logic              done;
    logic [CNT_W-1:0]  shift_value;
    logic              good_suffix_valid;
    logic [CNT_W-1:0]  pattern_length;
    logic [1:0]        status;
    logic              config_write = 1'b0;
    logic [6:0]        config_data = '0;

    // Shadow copy of the block state.
    logic [7:0] pat_bytes [MAX_PATTERN];
    logic       pat_exact [MAX_PATTERN];
    int         held_count;
    int         skip_entries [ALPHABET];
    int         suffix_len [MAX_PATTERN];
    int         gs_table [MAX_PATTERN];
    bit         skip_ready;
    bit         gs_ready;
    bit         overflowed;
    bit         closed;
    int         min_gs_length;

    answer_t    pending_answers [$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         sender_idle_pct = 0;

    boyer_moore_table_builder uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .operation         (operation),
        .byte_value        (byte_value),
        .exact_byte        (exact_byte),
        .last_byte         (last_byte),
        .position          (position),
        .done              (done),
        .shift_value       (shift_value),
        .good_suffix_valid (good_suffix_valid),
        .pattern_length    (pattern_length),
        .status            (status),
        .config_write      (config_write),
        .config_data       (config_data)
    );

    always #1 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // Bad-character skip table: every byte starts at the full length. An exact
    // byte before the last lowers its own entry to its distance from the end,
    // while a wildcard there lowers every entry.
    function automatic void compute_skip(input int n);
        int cap;
        for (int b = 0; b < ALPHABET; b++)
            skip_entries[b] = n;
        for (int i = 0; i + 1 < n; i++)
        begin
            cap = n - 1 - i;
            if (pat_exact[i])
            begin
                if (skip_entries[pat_bytes[i]] > cap)
                    skip_entries[pat_bytes[i]] = cap;
            end
            else
            begin
                for (int b = 0; b < ALPHABET; b++)
                    if (skip_entries[b] > cap)
                        skip_entries[b] = cap;
            end
        end
    endfunction

    // Good-suffix shifts. The suffix lengths are computed directly here, as
    // the longest common suffix of pattern[0..i] and the whole pattern.
    function automatic void compute_good_suffix(input int n);
        int l;
        int j;
        int s;
        suffix_len[n-1] = n;
        for (int i = 0; i < n - 1; i++)
        begin
            l = 0;
            while (l <= i && pat_bytes[i-l] == pat_bytes[n-1-l])
                l++;
            suffix_len[i] = l;
        end
        for (int k = 0; k < n; k++)
            gs_table[k] = n;
        j = 0;
        for (int p = n - 1; p >= 0; p--)
        begin
            if (suffix_len[p] == p + 1)
            begin
                for (; j < n - 1 - p; j++)
                    if (gs_table[j] == n)
                        gs_table[j] = n - 1 - p;
            end
        end
        for (int k = 0; k + 1 < n; k++)
        begin
            s = suffix_len[k];
            if (s <= n - 1 && gs_table[n-1-s] > n - 1 - k)
                gs_table[n-1-s] = n - 1 - k;
        end
    endfunction

    function automatic answer_t predict_answer(input op_t op, input logic [7:0] val,
                                               input logic ex, input logic lst,
                                               input logic [5:0] pos);
        answer_t a;
        bit every_exact;
        a.shift = '0;
        a.stat = ST_OK;
        case (op)
            OP_LOAD:
            begin
                // A load after a closed pattern starts a new one.
                if (closed)
                begin
                    held_count = 0;
                    overflowed = 0;
                    skip_ready = 0;
                    gs_ready = 0;
                    closed = 0;
                end
                if (held_count < MAX_PATTERN)
                begin
                    pat_bytes[held_count] = val;
                    pat_exact[held_count] = ex;
                    held_count++;
                end
                else
                    overflowed = 1;
                if (overflowed)
                    a.stat = ST_TOO_LONG;
                if (lst)
                begin
                    closed = 1;
                    if (!overflowed)
                    begin
                        compute_skip(held_count);
                        skip_ready = 1;
                        every_exact = 1;
                        for (int i = 0; i < held_count; i++)
                            if (!pat_exact[i])
                                every_exact = 0;
                        if (every_exact && held_count >= min_gs_length)
                        begin
                            compute_good_suffix(held_count);
                            gs_ready = 1;
                        end
                    end
                end
            end
            OP_QUERY_SKIP:
            begin
                if (!skip_ready)
                    a.stat = ST_NOT_BUILT;
                else
                    a.shift = 7'(skip_entries[val]);
            end
            OP_QUERY_GS:
            begin
                if (!skip_ready || !gs_ready)
                    a.stat = ST_NOT_BUILT;
                else if (pos >= held_count)
                    a.stat = ST_BAD_POS;
                else
                    a.shift = 7'(gs_table[pos]);
            end
            default:
            begin
            end
        endcase
        a.gs_valid = gs_ready;
        a.length = 7'(held_count);
        return a;
    endfunction

    // Each result strobe is checked against the oldest expected result.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("unexpected result, queue depth", 1, 0);
            else
            begin
                want = pending_answers.pop_front();
                if (shift_value !== want.shift)
                    report_mismatch("shift_value", shift_value, want.shift);
                if (good_suffix_valid !== want.gs_valid)
                    report_mismatch("good_suffix_valid", good_suffix_valid, want.gs_valid);
                if (pattern_length !== want.length)
                    report_mismatch("pattern_length", pattern_length, want.length);
                if (status !== want.stat)
                    report_mismatch("status", status, want.stat);
            end
        end
    end

    // Drive one transaction. Start stays high after acceptance so that
    // back-to-back transactions follow without a gap. The random gap lowers it.
    task automatic send_item(input op_t op, input logic [7:0] val, input logic ex,
                             input logic lst, input logic [5:0] pos);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(3)) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        operation <= op;
        byte_value <= val;
        exact_byte <= ex;
        last_byte <= lst;
        position <= pos;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_answers.push_back(predict_answer(op, val, ex, lst, pos));
    endtask

    // Let every expected result arrive and the build finish.
    task automatic wait_quiet();
        int calm;
        @(negedge clk);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        calm = 0;
        while (calm < 8)
        begin
            @(posedge clk);
            calm = busy ? 0 : calm + 1;
        end
    endtask

    task automatic write_min_length(input int value);
        wait_quiet();
        @(negedge clk);
        config_write <= 1'b1;
        config_data <= 7'(value);
        @(negedge clk);
        config_write <= 1'b0;
        min_gs_length = (value == 0) ? 1 : value;
    endtask

    task automatic load_pattern(input logic [7:0] bytes [$], input logic ex [$]);
        for (int i = 0; i < bytes.size(); i++)
            send_item(OP_LOAD, bytes[i], ex[i], i == bytes.size() - 1, '0);
    endtask

    task automatic test_directed();
        logic [7:0] b [$];
        logic e [$];
        // A query before any pattern exists.
        send_item(OP_QUERY_SKIP, 8'h00, 1'b0, 1'b0, 6'd0);
        send_item(OP_QUERY_GS, 8'h00, 1'b0, 1'b0, 6'd0);
        // One-byte pattern: too short for a good-suffix table.
        b = '{8'hff};
        e = '{1'b1};
        load_pattern(b, e);
        send_item(OP_QUERY_SKIP, 8'hff, 1'b0, 1'b0, 6'd0);
        send_item(OP_QUERY_GS, 8'h00, 1'b1, 1'b1, 6'd0);
        // Repeating exact pattern with a full good-suffix table.
        b = '{8'h41, 8'h42, 8'h43, 8'h41, 8'h42};
        e = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
        load_pattern(b, e);
        send_item(OP_QUERY_GS, 8'h00, 1'b0, 1'b0, 6'd0);
        send_item(OP_QUERY_GS, 8'h00, 1'b0, 1'b0, 6'd4);
        send_item(OP_QUERY_GS, 8'h00, 1'b0, 1'b0, 6'd5);
        send_item(OP_QUERY_GS, 8'hff, 1'b1, 1'b1, 6'd63);
        send_item(OP_QUERY_SKIP, 8'h41, 1'b0, 1'b0, 6'd0);
        send_item(OP_QUERY_SKIP, 8'h00, 1'b0, 1'b0, 6'd0);
        // The unused operation changes nothing.
        send_item(OP_UNUSED, 8'hff, 1'b1, 1'b1, 6'd63);
        // Pattern with a wildcard: the skip is capped and there is no good suffix.
        b = '{8'h00, 8'h55, 8'h00, 8'hff};
        e = '{1'b1, 1'b0, 1'b1, 1'b1};
        load_pattern(b, e);
        send_item(OP_QUERY_SKIP, 8'h7f, 1'b0, 1'b0, 6'd0);
        send_item(OP_QUERY_SKIP, 8'h00, 1'b0, 1'b0, 6'd0);
        send_item(OP_QUERY_GS, 8'h00, 1'b0, 1'b0, 6'd1);
        // A query in the middle of a new pattern sees no tables.
        send_item(OP_LOAD, 8'h12, 1'b1, 1'b0, 6'd0);
        send_item(OP_QUERY_SKIP, 8'h12, 1'b0, 1'b0, 6'd0);
        send_item(OP_LOAD, 8'h34, 1'b1, 1'b1, 6'd0);
        send_item(OP_QUERY_SKIP, 8'h12, 1'b0, 1'b0, 6'd0);
    endtask

    // Full-capacity pattern, then one that runs past the capacity.
    task automatic test_capacity();
        for (int i = 0; i < MAX_PATTERN; i++)
            send_item(OP_LOAD, 8'($urandom_range(1)), 1'b1, i == MAX_PATTERN - 1, '0);
        send_item(OP_QUERY_GS, 8'h00, 1'b0, 1'b0, 6'd63);
        send_item(OP_QUERY_GS, 8'h00, 1'b0, 1'b0, 6'd0);
        send_item(OP_QUERY_SKIP, 8'h01, 1'b0, 1'b0, 6'd0);
        for (int i = 0; i < MAX_PATTERN + 3; i++)
            send_item(OP_LOAD, 8'($urandom), 1'b1, i == MAX_PATTERN + 2, '0);
        send_item(OP_QUERY_SKIP, 8'h00, 1'b0, 1'b0, 6'd0);
        send_item(OP_QUERY_GS, 8'h00, 1'b0, 1'b0, 6'd0);
    endtask

    // Random patterns followed by a burst of queries. Bytes mostly come from a
    // tiny alphabet so that suffixes repeat and the shift table gets exercised.
    task automatic test_random(input int items);
        int sent;
        int len;
        int pick;
        int queries;
        bit tiny;
        bit wild;
        logic [7:0] val;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(99);
            len = (pick < 80) ? $urandom_range(1, 12) :
                  (pick < 96) ? $urandom_range(13, MAX_PATTERN) :
                                $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 4);
            tiny = $urandom_range(99) < 75;
            wild = $urandom_range(99) < 25;
            for (int i = 0; i < len; i++)
            begin
                val = tiny ? 8'($urandom_range(2)) : 8'($urandom);
                send_item(OP_LOAD, val, !(wild && $urandom_range(3) == 0),
                          i == len - 1, 6'($urandom));
                if ($urandom_range(99) < 2)
                    send_item(op_t'($urandom_range(1, 3)), 8'($urandom), 1'b0, 1'b0,
                              6'($urandom));
            end
            sent += len;
            queries = $urandom_range(2, 10);
            for (int q = 0; q < queries; q++)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    send_item(OP_QUERY_SKIP, tiny && pick < 25 ? 8'($urandom_range(3)) :
                              8'($urandom), 1'($urandom), 1'($urandom), 6'($urandom));
                else if (pick < 95)
                    send_item(OP_QUERY_GS, 8'($urandom), 1'($urandom), 1'($urandom),
                              pick < 85 ? 6'($urandom_range(len > 64 ? 63 : len - 1)) :
                                          6'($urandom));
                else
                    send_item(OP_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom),
                              6'($urandom));
            end
            sent += queries;
        end
    endtask

    // The sender holds off until every result is back, then goes on.
    task automatic test_drain_pause();
        logic [7:0] b [$];
        logic e [$];
        b = '{8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01};
        e = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
        load_pattern(b, e);
        wait_quiet();
        for (int p = 0; p < 7; p++)
            send_item(OP_QUERY_GS, 8'h01, 1'b0, 1'b0, 6'(p));
    endtask

    initial
    begin
        held_count = 0;
        skip_ready = 0;
        gs_ready = 0;
        overflowed = 0;
        closed = 0;
        min_gs_length = 4;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 14;
        test_directed();
        test_capacity();
        write_min_length(1);
        test_random(400);
        write_min_length(MAX_PATTERN);
        test_capacity();
        sender_idle_pct = 51;
        write_min_length(0);
        test_drain_pause();
        test_random(350);
        write_min_length(127);
        test_random(100);
        sender_idle_pct = 0;
        write_min_length(3);
        test_random(300);

        wait_quiet();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
